// ===== hw/rtl/b64e_pkg.sv =====
package b64e_pkg;

  localparam int BYTE_W      = 8;
  localparam int SYM_W       = 7;
  localparam int IDX_W       = 6;
  localparam int GROUP_W     = 24;
  localparam int HELD_W      = 16;
  localparam int ALPHA_WORDS = 7;
  localparam int ALPHA_SYMS  = 64;
  localparam int APB_AW      = 6;
  localparam int APB_DW      = 64;
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  localparam logic [SYM_W-1:0] PAD_RESET = 7'd61;

  // register indexes (paddr[5:3])
  localparam logic [2:0] REG_ALPHA_LAST = 3'd6;
  localparam logic [2:0] REG_PAD_SYMBOL = 3'd7;

  // one closed group handed from front to back
  typedef struct packed {
    logic [GROUP_W-1:0] group;
    logic [1:0]         pads;
    logic               last;
  } group_t;

  typedef struct packed {
    logic              full;
    logic              empty;
    logic [QCNT_W-1:0] count;
  } q_status_t;

endpackage

// ===== hw/rtl/b64e_in_if.sv =====
interface b64e_in_if;
  logic                         valid;
  logic                         ready;
  logic [b64e_pkg::BYTE_W-1:0]  data_byte;
  logic                         stream_last;

  modport source (output valid, output data_byte, output stream_last, input ready);
  modport sink (input valid, input data_byte, input stream_last, output ready);
endinterface

// ===== hw/rtl/b64e_out_if.sv =====
interface b64e_out_if;
  logic                        valid;
  logic                        ready;
  logic [b64e_pkg::SYM_W-1:0]  symbol;
  logic                        run_last;
  logic                        stream_end;

  modport source (output valid, output symbol, output run_last, output stream_end,
                  input ready);
  modport sink (input valid, input symbol, input run_last, input stream_end,
                output ready);
endinterface

// ===== hw/rtl/b64e_front.sv =====
module b64e_front (
  input  logic              clk,
  input  logic              rst,
  b64e_in_if.sink           bytes,
  input  logic              q_full,
  output logic              push,
  output b64e_pkg::group_t  push_data
);

  logic [b64e_pkg::HELD_W-1:0] held_bytes;
  logic [b64e_pkg::HELD_W-1:0] held_bytes_next;
  logic [1:0]                  held_count;
  logic [1:0]                  held_count_next;
  logic                        accept;
  logic                        closes;

  assign bytes.ready = !q_full;
  assign accept      = bytes.valid && bytes.ready;

  // count of three cannot occur; it is treated as two
  assign closes = bytes.stream_last || held_count[1];

  always_comb begin
    push_data.last = bytes.stream_last;
    priority if (held_count == 2'd0) begin
      push_data.group = {bytes.data_byte, 16'h0000};
      push_data.pads  = 2'd2;
    end else if (held_count == 2'd1) begin
      push_data.group = {held_bytes[7:0], bytes.data_byte, 8'h00};
      push_data.pads  = 2'd1;
    end else begin
      push_data.group = {held_bytes, bytes.data_byte};
      push_data.pads  = 2'd0;
    end
  end

  assign push = accept && closes;

  always_comb begin
    held_bytes_next = held_bytes;
    held_count_next = held_count;
    if (accept) begin
      if (closes) begin
        held_bytes_next = '0;
        held_count_next = 2'd0;
      end else begin
        held_bytes_next = {held_bytes[7:0], bytes.data_byte};
        held_count_next = held_count + 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      held_bytes <= '0;
      held_count <= 2'd0;
    end else begin
      held_bytes <= held_bytes_next;
      held_count <= held_count_next;
    end
  end

endmodule

// ===== hw/rtl/b64e_queue.sv =====
module b64e_queue (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 push,
  input  b64e_pkg::group_t     push_data,
  input  logic                 pop,
  output b64e_pkg::group_t     head,
  output b64e_pkg::q_status_t  status
);

  b64e_pkg::group_t                 entries [b64e_pkg::QUEUE_DEPTH];
  logic [b64e_pkg::QPTR_W-1:0]      wr_ptr;
  logic [b64e_pkg::QPTR_W-1:0]      rd_ptr;
  logic [b64e_pkg::QCNT_W-1:0]      count;
  logic                             do_push;
  logic                             do_pop;

  assign status.count = count;
  assign status.full  = (count == b64e_pkg::QCNT_W'(b64e_pkg::QUEUE_DEPTH));
  assign status.empty = (count == '0);
  assign head         = entries[rd_ptr];

  assign do_push = push && !status.full;
  assign do_pop  = pop && !status.empty;

  always_ff @(posedge clk) begin
    if (do_push) begin
      entries[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      unique case ({do_push, do_pop})
        2'b10:   count <= count + b64e_pkg::QCNT_W'(1);
        2'b01:   count <= count - b64e_pkg::QCNT_W'(1);
        default: count <= count;
      endcase
    end
  end

endmodule

// ===== hw/rtl/b64e_back.sv =====
module b64e_back (
  input  logic                                                  clk,
  input  logic                                                  rst,
  input  b64e_pkg::group_t                                      head,
  input  logic                                                  q_empty,
  output logic                                                  pop,
  input  logic [b64e_pkg::ALPHA_SYMS*b64e_pkg::SYM_W-1:0]       alphabet,
  input  logic [b64e_pkg::SYM_W-1:0]                            pad_symbol,
  b64e_out_if.source                                            symbols
);

  logic [b64e_pkg::ALPHA_SYMS-1:0][b64e_pkg::SYM_W-1:0] alpha_tab;
  logic [1:0]                    slot;
  logic [b64e_pkg::IDX_W-1:0]    idx;
  logic                          is_pad;
  logic                          load;
  logic                          out_valid;
  logic [b64e_pkg::SYM_W-1:0]    out_symbol;
  logic                          out_run_last;
  logic                          out_stream_end;
  logic [b64e_pkg::SYM_W-1:0]    sym_next;

  assign alpha_tab = alphabet;

  // output register frees when empty or taken this cycle
  assign load = !q_empty && (!out_valid || symbols.ready);
  assign pop  = load && (slot == 2'd3);

  always_comb begin
    unique case (slot)
      2'd0: idx = head.group[23:18];
      2'd1: idx = head.group[17:12];
      2'd2: idx = head.group[11:6];
      2'd3: idx = head.group[5:0];
      default: idx = '0;
    endcase
  end

  // one pad: last slot; two pads: last two slots
  assign is_pad   = (head.pads == 2'd2 && slot[1]) || (head.pads == 2'd1 && slot == 2'd3);
  assign sym_next = is_pad ? pad_symbol : alpha_tab[idx];

  always_ff @(posedge clk) begin
    if (load) begin
      out_symbol     <= sym_next;
      out_run_last   <= (slot == 2'd3);
      out_stream_end <= (slot == 2'd3) && head.last;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      slot      <= 2'd0;
    end else begin
      if (load) begin
        out_valid <= 1'b1;
        slot      <= slot + 2'd1;
      end else if (symbols.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  assign symbols.valid      = out_valid;
  assign symbols.symbol     = out_symbol;
  assign symbols.run_last   = out_run_last;
  assign symbols.stream_end = out_stream_end;

endmodule

// ===== hw/rtl/base64_stream_encoder.sv =====
// Base64 encoder with a programmable 64-entry, 7-bit alphabet.
// bytes: one raw byte per request with a stream_last flag. Bytes are held
// until three form a group, or until stream_last closes a shorter group,
// which is zero-filled and padded with pad_symbol (two pads after one byte,
// one pad after two).
// symbols: four requests per group, most significant 6-bit slice first;
// run_last marks the fourth, stream_end the fourth of the group closed by
// stream_last.
// The first symbol of a group passes through the group queue and the output
// register after the byte that closes it. Throughput is set by the single output
// register: one symbol per cycle while symbols is ready. A two-entry group queue
// lets the byte side run ahead by up to two groups, one byte per cycle while the
// queue is not full.
// When symbols is stalled the output register holds; bytes keeps being taken
// until the queue fills.
// Config (APB, 64-bit data): register i at byte address 8*i. Words 0..6 hold
// the packed alphabet (symbol i at bits 7i+6..7i), word 7 holds pad_symbol.
// Reset clears held bytes, queue and output; alphabet goes to zero and
// pad_symbol to 61.
module base64_stream_encoder (
  input  logic                           clk,
  input  logic                           rst,
  b64e_in_if.sink                        bytes,
  b64e_out_if.source                     symbols,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [b64e_pkg::APB_AW-1:0]    paddr,
  input  logic [b64e_pkg::APB_DW-1:0]    pwdata,
  output logic [b64e_pkg::APB_DW-1:0]    prdata,
  output logic                           pready
);

  logic [b64e_pkg::ALPHA_WORDS-1:0][b64e_pkg::APB_DW-1:0] alpha_words;
  logic [b64e_pkg::SYM_W-1:0]  pad_symbol;
  logic [2:0]                  reg_idx;
  logic                        cfg_write;
  logic                        push;
  logic                        pop;
  b64e_pkg::group_t            push_data;
  b64e_pkg::group_t            head;
  b64e_pkg::q_status_t         q_status;

  assign pready    = 1'b1;
  assign reg_idx   = paddr[5:3];
  assign cfg_write = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      alpha_words <= '0;
      pad_symbol  <= b64e_pkg::PAD_RESET;
    end else if (cfg_write) begin
      if (reg_idx == b64e_pkg::REG_PAD_SYMBOL) begin
        pad_symbol <= pwdata[b64e_pkg::SYM_W-1:0];
      end else begin
        alpha_words[reg_idx] <= pwdata;
      end
    end
  end

  always_comb begin
    if (reg_idx == b64e_pkg::REG_PAD_SYMBOL) begin
      prdata = {{(b64e_pkg::APB_DW-b64e_pkg::SYM_W){1'b0}}, pad_symbol};
    end else begin
      prdata = alpha_words[reg_idx];
    end
  end

  b64e_front u_front (
    .clk       (clk),
    .rst       (rst),
    .bytes     (bytes),
    .q_full    (q_status.full),
    .push      (push),
    .push_data (push_data)
  );

  b64e_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (push_data),
    .pop       (pop),
    .head      (head),
    .status    (q_status)
  );

  b64e_back u_back (
    .clk        (clk),
    .rst        (rst),
    .head       (head),
    .q_empty    (q_status.empty),
    .pop        (pop),
    .alphabet   (alpha_words),
    .pad_symbol (pad_symbol),
    .symbols    (symbols)
  );

  a_stream_end_on_fourth: assert property (@(posedge clk) disable iff (rst)
    symbols.valid && symbols.stream_end |-> symbols.run_last)
    else $error("stream_end without run_last");

  a_queue_bound: assert property (@(posedge clk) disable iff (rst)
    q_status.count <= b64e_pkg::QCNT_W'(b64e_pkg::QUEUE_DEPTH))
    else $error("group queue over depth");

  a_last_makes_group: assert property (@(posedge clk) disable iff (rst)
    bytes.valid && bytes.ready && bytes.stream_last |=> !q_status.empty)
    else $error("last byte did not queue a group");

  a_pop_ends_group: assert property (@(posedge clk) disable iff (rst)
    pop |=> symbols.valid && symbols.run_last)
    else $error("group retired without a fourth symbol");

endmodule

// ===== tb/sv/tb_base64_stream_encoder.sv =====
`timescale 1ns / 1ps

module tb_base64_stream_encoder;
  import b64e_pkg::*;

  localparam int ALPHA_BITS = ALPHA_WORDS * APB_DW;
  localparam int HOLD_OFF_CYCLES = 300;

  typedef struct packed {
    logic [SYM_W-1:0] symbol;
    logic             run_last;
    logic             stream_end;
  } sym_item_t;

  logic clk;
  logic rst;
  logic psel;
  logic penable;
  logic pwrite;
  logic [APB_AW-1:0] paddr;
  logic [APB_DW-1:0] pwdata;
  logic [APB_DW-1:0] prdata;
  logic pready;

  b64e_in_if bytes_if ();
  b64e_out_if syms_if ();

  base64_stream_encoder i_dut (
    .clk     (clk),
    .rst     (rst),
    .bytes   (bytes_if.sink),
    .symbols (syms_if.source),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  // shadow of the encoder state
  logic [ALPHA_BITS-1:0] alphabet_shadow;
  logic [SYM_W-1:0]      pad_shadow;
  logic [HELD_W-1:0]     held_shadow;
  logic [1:0]            held_cnt_shadow;

  sym_item_t expected_syms[$];

  int src_idle_pct;
  int snk_stall_pct;
  int mismatches;
  int bytes_sent;
  int streams_sent;
  int syms_checked;
  int cfg_writes;
  logic hold_active;
  event hold_off;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #3_000_000;
    $display("tb_base64_stream_encoder: done, errors");
    $finish;
  end

  // long receiver hold-off, timed here so the sender keeps pushing
  always begin
    @(hold_off);
    hold_active <= 1'b1;
    repeat (HOLD_OFF_CYCLES) @(posedge clk);
    hold_active <= 1'b0;
  end

  // symbol side: check each accepted request, then pick next ready
  always @(posedge clk) begin
    if (!rst && syms_if.valid && syms_if.ready) check_symbol();
    if (hold_active) begin
      syms_if.ready <= 1'b0;
    end else begin
      syms_if.ready <= ($urandom_range(99) >= snk_stall_pct);
    end
  end

  task automatic check_symbol();
    sym_item_t exp_s;
    if (expected_syms.size() == 0) begin
      mismatches++;
      if (mismatches <= 10)
        $display("unexpected symbol %h run_last %b stream_end %b",
                 syms_if.symbol, syms_if.run_last, syms_if.stream_end);
    end else begin
      exp_s = expected_syms.pop_front();
      syms_checked++;
      if (exp_s.symbol !== syms_if.symbol || exp_s.run_last !== syms_if.run_last ||
          exp_s.stream_end !== syms_if.stream_end) begin
        mismatches++;
        if (mismatches <= 10)
          $display("symbol mismatch: expected %h/%b/%b, got %h/%b/%b",
                   exp_s.symbol, exp_s.run_last, exp_s.stream_end,
                   syms_if.symbol, syms_if.run_last, syms_if.stream_end);
      end
    end
  endtask

  // group bytes, emit four symbols when a group closes
  function automatic void encode_byte(input logic [BYTE_W-1:0] b, input logic lst);
    logic [GROUP_W-1:0] grp;
    logic [IDX_W-1:0]   idx;
    sym_item_t          s;
    int                 n;
    int                 pads;
    n = int'(held_cnt_shadow) + 1;
    if (n < 3 && !lst) begin
      held_shadow = {held_shadow[7:0], b};
      held_cnt_shadow = 2'(n);
      return;
    end
    case (held_cnt_shadow)
      2'd0:    grp = {b, 16'h0000};
      2'd1:    grp = {held_shadow[7:0], b, 8'h00};
      default: grp = {held_shadow, b};
    endcase
    pads = 3 - n;
    for (int k = 0; k < 4; k++) begin
      idx = grp[18 - 6 * k +: IDX_W];
      s.symbol = (k >= 4 - pads) ? pad_shadow : alphabet_shadow[int'(idx) * SYM_W +: SYM_W];
      s.run_last = (k == 3);
      s.stream_end = (k == 3) && lst;
      expected_syms.insert(expected_syms.size(), s);
    end
    held_shadow = '0;
    held_cnt_shadow = '0;
  endfunction

  task automatic send_byte(input logic [BYTE_W-1:0] b, input logic lst);
    if ($urandom_range(99) < src_idle_pct) begin
      bytes_if.valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < src_idle_pct);
    end
    bytes_if.valid <= 1'b1;
    bytes_if.data_byte <= b;
    bytes_if.stream_last <= lst;
    do @(posedge clk); while (!bytes_if.ready);
    encode_byte(b, lst);
    bytes_sent++;
    if (lst) streams_sent++;
  endtask

  task automatic send_random_stream(input int len);
    for (int i = 0; i < len; i++) send_byte(8'($urandom), i == len - 1);
  endtask

  task automatic wait_drain();
    bytes_if.valid <= 1'b0;
    while (expected_syms.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  // leaves the bus selected; the caller closes the last transfer
  task automatic cfg_write(input logic [2:0] reg_idx, input logic [APB_DW-1:0] val);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {reg_idx, 3'b000};
    pwdata <= val;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    if (reg_idx == REG_PAD_SYMBOL) pad_shadow = val[SYM_W-1:0];
    else alphabet_shadow[int'(reg_idx) * APB_DW +: APB_DW] = val;
    cfg_writes++;
  endtask

  task automatic program_alphabet(input logic [ALPHA_BITS-1:0] a, input logic [APB_DW-1:0] pad);
    wait_drain();
    for (int k = 0; k <= int'(REG_ALPHA_LAST); k++) cfg_write(3'(k), a[k * APB_DW +: APB_DW]);
    cfg_write(REG_PAD_SYMBOL, pad);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
  endtask

  function automatic logic [ALPHA_BITS-1:0] std_alphabet();
    string chars;
    byte   ch;
    logic [ALPHA_BITS-1:0] a;
    chars = "ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz0123456789+/";
    a = '0;
    for (int i = 0; i < ALPHA_SYMS; i++) begin
      ch = chars[i];
      a[i * SYM_W +: SYM_W] = ch[SYM_W-1:0];
    end
    return a;
  endfunction

  function automatic logic [ALPHA_BITS-1:0] rand_alphabet();
    logic [ALPHA_BITS-1:0] a;
    for (int k = 0; k < ALPHA_BITS / 32; k++) a[k * 32 +: 32] = $urandom;
    return a;
  endfunction

  // alphabet all zero and pad at its reset value
  task automatic test_reset_state();
    send_byte(8'h12, 1'b0);
    send_byte(8'h34, 1'b0);
    send_byte(8'h56, 1'b1);
    send_byte(8'hFF, 1'b1);
    wait_drain();
  endtask

  // full groups, group closed by last, one and two leftover bytes
  task automatic test_directed_groups();
    program_alphabet(std_alphabet(), 64'd61);
    send_byte(8'h4D, 1'b0);
    send_byte(8'h61, 1'b0);
    send_byte(8'h6E, 1'b0);
    send_byte(8'h00, 1'b0);
    send_byte(8'h00, 1'b0);
    send_byte(8'h00, 1'b0);
    send_byte(8'hFF, 1'b0);
    send_byte(8'hFF, 1'b0);
    send_byte(8'hFF, 1'b1);
    send_byte(8'hFF, 1'b1);
    send_byte(8'h00, 1'b1);
    send_byte(8'hAB, 1'b0);
    send_byte(8'hCD, 1'b1);
    send_byte(8'h00, 1'b0);
    send_byte(8'hFF, 1'b1);
    wait_drain();
  endtask

  task automatic test_alphabet_extremes();
    program_alphabet('1, 64'd0);
    send_byte(8'h5A, 1'b0);
    send_byte(8'hA5, 1'b1);
    program_alphabet('0, {APB_DW{1'b1}});
    send_byte(8'h01, 1'b1);
    wait_drain();
  endtask

  task automatic test_random_streams();
    int src_pct[4] = '{0, 59, 0, 31};
    int snk_pct[4] = '{0, 0, 59, 31};
    int sent;
    int len;
    for (int ph = 0; ph < 4; ph++) begin
      program_alphabet(rand_alphabet(), {$urandom, $urandom});
      src_idle_pct = src_pct[ph];
      snk_stall_pct = snk_pct[ph];
      sent = 0;
      while (sent < 32) begin
        len = $urandom_range(1, 10);
        if (len > 32 - sent) len = 32 - sent;
        send_random_stream(len);
        sent += len;
      end
      wait_drain();
    end
  endtask

  // receiver holds off while bytes keep coming, so the group queue fills
  task automatic test_backpressure();
    program_alphabet(std_alphabet(), 64'd61);
    src_idle_pct = 0;
    snk_stall_pct = 20;
    @(posedge clk);
    -> hold_off;
    send_random_stream(7);
    send_random_stream(8);
    send_random_stream(5);
    wait_drain();
  endtask

  initial begin
    rst = 1'b1;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    bytes_if.valid = 1'b0;
    bytes_if.data_byte = '0;
    bytes_if.stream_last = 1'b0;
    syms_if.ready = 1'b0;
    hold_active = 1'b0;
    src_idle_pct = 0;
    snk_stall_pct = 0;
    mismatches = 0;
    bytes_sent = 0;
    streams_sent = 0;
    syms_checked = 0;
    cfg_writes = 0;
    alphabet_shadow = '0;
    pad_shadow = PAD_RESET;
    held_shadow = '0;
    held_cnt_shadow = '0;
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_reset_state();
    test_directed_groups();
    test_alphabet_extremes();
    test_random_streams();
    test_backpressure();

    wait_drain();
    if (expected_syms.size() != 0) begin
      mismatches += expected_syms.size();
      $display("%0d expected symbols never arrived", expected_syms.size());
    end
    $display("covered %0d bytes in %0d streams, %0d symbols checked, %0d register writes",
             bytes_sent, streams_sent, syms_checked, cfg_writes);
    $display("idle modes: none, sender, receiver, both; one long receiver hold-off");
    if (mismatches == 0) begin
      $display("tb_base64_stream_encoder: done, clean");
    end else begin
      $display("tb_base64_stream_encoder: done, errors");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
hw/rtl/b64e_pkg.sv
hw/rtl/b64e_in_if.sv
hw/rtl/b64e_out_if.sv
hw/rtl/b64e_front.sv
hw/rtl/b64e_queue.sv
hw/rtl/b64e_back.sv
hw/rtl/base64_stream_encoder.sv
tb/sv/tb_base64_stream_encoder.sv
